@@ hw/rtl/sss_pkg.sv @@
// Shared codes, field widths and types for the segmented stack set.
// Used by sss_ctrl and segmented_stack_set; no dependencies of its own.
`timescale 1ns / 1ps

package sss_pkg;

    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 4;
    localparam int CFG_W  = 5;

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_AT = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BEYOND = 2'd3;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic              pop_ok;
        logic [STAT_W-1:0] status;
    } t_stat;

endpackage

@@ hw/rtl/sss_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module sss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/sss_ctrl.sv @@
// Control for the segmented stack set: fill counts, current sub-stack, capacity register,
// and the per-item decision that drives the value RAM. Depends on sss_pkg.
`timescale 1ns / 1ps

module sss_ctrl
    import sss_pkg::*;
#(
    parameter int NUM_SUB_STACKS = 16,
    parameter int MAX_CAPACITY   = 16,
    parameter int DATA_WIDTH     = 32,
    localparam int SW = $clog2(NUM_SUB_STACKS),
    localparam int IW = (SW > IDX_W) ? SW : IDX_W,
    localparam int AW = $clog2(NUM_SUB_STACKS * MAX_CAPACITY)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  i_fire,
    input  logic [OP_W-1:0]       i_op,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [IW-1:0]         i_idx,
    output t_stat                 o_stat,
    output logic [SW-1:0]         o_cur,
    output logic                  o_ram_we,
    output logic [AW-1:0]         o_ram_waddr,
    output logic [DATA_WIDTH-1:0] o_ram_wdata,
    output logic                  o_ram_re,
    output logic [AW-1:0]         o_ram_raddr
);

    localparam int CW = $clog2(MAX_CAPACITY + 1);
    localparam int XW = (CW > CFG_W) ? CW : CFG_W;

    logic [CFG_W-1:0] r_cap;
    logic [CW-1:0]    r_fill [NUM_SUB_STACKS];
    logic [SW-1:0]    r_cur;
    logic [CW-1:0]    r_cur_fill;

    logic [SW-1:0]    n_cur;
    logic [CW-1:0]    n_cur_fill;

    logic [XW-1:0]    cap_raw;
    logic [XW-1:0]    cap_eff;
    logic             cur_is_last;
    logic             idx_lt_cur;
    logic [SW-1:0]    rd_sel;
    logic [CW-1:0]    rd_fill;
    logic             fw_en;
    logic [SW-1:0]    fw_sel;
    logic [CW-1:0]    fw_val;
    t_stat            stat;

    function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s, input logic [CW-1:0] f);
        slot_addr = AW'(s) * AW'(MAX_CAPACITY) + AW'(f);
    endfunction

    // A zero capacity acts as one; anything above the store's row size saturates.
    always_comb begin
        cap_raw = XW'(r_cap);
        if (cap_raw == '0) begin
            cap_eff = XW'(1);
        end else if (cap_raw > XW'(MAX_CAPACITY)) begin
            cap_eff = XW'(MAX_CAPACITY);
        end else begin
            cap_eff = cap_raw;
        end
    end

    assign cur_is_last = (r_cur == SW'(NUM_SUB_STACKS - 1));
    assign idx_lt_cur  = (i_idx < IW'(r_cur));

    // Sub-stacks above the current one are always empty, so only one count is read from
    // the array: the named sub-stack for a pop below the current one, otherwise the one
    // below current, which becomes current if this item empties the current sub-stack.
    assign rd_sel  = (i_op == OP_POP_AT && idx_lt_cur) ? i_idx[SW-1:0] : r_cur - 1'b1;
    assign rd_fill = r_fill[rd_sel];

    always_comb begin
        n_cur       = r_cur;
        n_cur_fill  = r_cur_fill;
        fw_en       = 1'b0;
        fw_sel      = r_cur;
        fw_val      = r_cur_fill;
        stat        = '{pop_ok: 1'b0, status: ST_OK};
        o_ram_we    = 1'b0;
        o_ram_waddr = slot_addr(r_cur, r_cur_fill);
        o_ram_wdata = i_value;
        o_ram_re    = 1'b0;
        o_ram_raddr = slot_addr(r_cur, r_cur_fill - 1'b1);

        case (i_op) inside
            OP_PUSH: begin
                if (XW'(r_cur_fill) >= cap_eff) begin
                    if (cur_is_last) begin
                        stat.status = ST_FULL;
                    end else begin
                        n_cur       = r_cur + 1'b1;
                        n_cur_fill  = CW'(1);
                        fw_en       = 1'b1;
                        fw_sel      = r_cur + 1'b1;
                        fw_val      = CW'(1);
                        o_ram_we    = 1'b1;
                        o_ram_waddr = slot_addr(r_cur + 1'b1, '0);
                    end
                end else begin
                    n_cur_fill = r_cur_fill + 1'b1;
                    fw_en      = 1'b1;
                    fw_val     = r_cur_fill + 1'b1;
                    o_ram_we   = 1'b1;
                end
            end
            OP_POP, OP_POP_AT: begin
                if (i_op == OP_POP_AT && i_idx > IW'(r_cur)) begin
                    stat.status = ST_BEYOND;
                end else if (i_op == OP_POP_AT && idx_lt_cur) begin
                    if (rd_fill == '0) begin
                        stat.status = ST_EMPTY;
                    end else begin
                        stat.pop_ok = 1'b1;
                        fw_en       = 1'b1;
                        fw_sel      = i_idx[SW-1:0];
                        fw_val      = rd_fill - 1'b1;
                        o_ram_re    = 1'b1;
                        o_ram_raddr = slot_addr(i_idx[SW-1:0], rd_fill - 1'b1);
                    end
                end else if (r_cur_fill == '0) begin
                    stat.status = ST_EMPTY;
                end else begin
                    stat.pop_ok = 1'b1;
                    fw_en       = 1'b1;
                    fw_val      = r_cur_fill - 1'b1;
                    o_ram_re    = 1'b1;
                    if (r_cur_fill == CW'(1) && r_cur != '0) begin
                        n_cur      = r_cur - 1'b1;
                        n_cur_fill = rd_fill;
                    end else begin
                        n_cur_fill = r_cur_fill - 1'b1;
                    end
                end
            end
            default: begin
                stat.status = ST_OK;
            end
        endcase

        if (!i_fire) begin
            o_ram_we = 1'b0;
            o_ram_re = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= CAP_RESET;
            r_cur      <= '0;
            r_cur_fill <= '0;
            for (int i = 0; i < NUM_SUB_STACKS; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_cur      <= n_cur;
                r_cur_fill <= n_cur_fill;
                if (fw_en) begin
                    r_fill[fw_sel] <= fw_val;
                end
            end
        end
    end

    assign o_stat = stat;
    assign o_cur  = n_cur;

`ifndef NO_ASSERTIONS
    a_cur_fill_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_fill == r_fill[r_cur])
        else $error("current fill register differs from the fill count array");

    a_above_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cur_is_last |-> r_fill[r_cur + 1'b1] == '0)
        else $error("sub-stack above the current one is not empty");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_cur_fill) <= XW'(MAX_CAPACITY))
        else $error("fill count exceeds the row size");

    a_step_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && n_cur != r_cur && i_op != OP_PUSH |-> stat.pop_ok && r_cur_fill == CW'(1))
        else $error("current sub-stack moved back without emptying");
`endif

endmodule

@@ hw/rtl/segmented_stack_set.sv @@
// Segmented stack set: one item per cycle; an accepted item waits in the input register, and
// its count update and registered RAM read happen together as its result is registered for output.
// The store is a fixed row of sub-stacks with a shared capacity register; pushes fill the
// current sub-stack and move on to the next when it is full, pops take from the current or a
// named sub-stack, and the current index steps back when its sub-stack empties. The block
// takes a new item every cycle as long as results are taken; an item waiting on a stalled
// result is held in the input register. Depends on sss_pkg, sss_ctrl and sss_ram.
`timescale 1ns / 1ps

module segmented_stack_set
    import sss_pkg::*;
#(
    parameter int NUM_SUB_STACKS = 16,
    parameter int MAX_CAPACITY   = 16,
    parameter int DATA_WIDTH     = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [OP_W-1:0]       i_op,
    input  logic [DATA_WIDTH-1:0] i_push_value,
    input  logic [IDX_W-1:0]      i_sub_stack_index,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [DATA_WIDTH-1:0] o_popped_value,
    output logic [STAT_W-1:0]     o_status,
    output logic [IDX_W-1:0]      o_current_index
);

    localparam int SW = $clog2(NUM_SUB_STACKS);
    localparam int IW = (SW > IDX_W) ? SW : IDX_W;
    localparam int AW = $clog2(NUM_SUB_STACKS * MAX_CAPACITY);

    logic                  r_s1_valid;
    logic [OP_W-1:0]       r_op;
    logic [DATA_WIDTH-1:0] r_value;
    logic [IDX_W-1:0]      r_idx;

    logic                  r_out_valid;
    logic                  r_out_pop_ok;
    logic [STAT_W-1:0]     r_out_status;
    logic [IDX_W-1:0]      r_out_cur;

    logic                  advance;
    logic                  fire;
    t_stat                 stat;
    logic [SW-1:0]         cur;
    logic [IW-1:0]         cur_ext;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    assign advance = !r_out_valid || !i_stall;
    assign fire    = r_s1_valid && advance;
    assign o_stall = r_s1_valid && !advance;
    assign cur_ext = IW'(cur);

    sss_ctrl #(
        .NUM_SUB_STACKS (NUM_SUB_STACKS),
        .MAX_CAPACITY   (MAX_CAPACITY),
        .DATA_WIDTH     (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_op        (r_op),
        .i_value     (r_value),
        .i_idx       (IW'(r_idx)),
        .o_stat      (stat),
        .o_cur       (cur),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr)
    );

    sss_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (NUM_SUB_STACKS * MAX_CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_s1_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_op    <= i_op;
            r_value <= i_push_value;
            r_idx   <= i_sub_stack_index;
        end
        if (fire) begin
            r_out_pop_ok <= stat.pop_ok;
            r_out_status <= stat.status;
            r_out_cur    <= cur_ext[IDX_W-1:0];
        end
    end

    // The RAM read data holds until the next pop, so it stays valid while the result stalls.
    assign o_valid         = r_out_valid;
    assign o_popped_value  = r_out_pop_ok ? ram_rdata : '0;
    assign o_status        = r_out_status;
    assign o_current_index = r_out_cur;

`ifndef NO_ASSERTIONS
    a_pop_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_pop_ok |-> r_out_status == ST_OK)
        else $error("successful pop reported with an error status");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |-> !ram_re && !ram_we)
        else $error("store accessed while the result is stalled");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid && r_out_valid && i_stall)
        else $error("input stalled while the block has room");
`endif

endmodule

@@ tb/tb_segmented_stack_set.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for segmented_stack_set: directed corner items, then random runs
// under several capacities, each result checked against a behavioral model of the stacks.
// Depends on sss_pkg and the segmented_stack_set RTL.

class stack_set_scoreboard;
    typedef struct {
        logic [31:0]               value;
        logic [sss_pkg::STAT_W-1:0] status;
        logic [sss_pkg::IDX_W-1:0]  cur;
    } t_stack_result;

    logic [31:0]               plates [16][16];
    logic [4:0]                fill [16];
    logic [sss_pkg::IDX_W-1:0] cur_sub;
    logic [sss_pkg::CFG_W-1:0] capacity;
    t_stack_result             pending_results [$];
    int                        errors;

    function new();
        foreach (fill[i]) fill[i] = '0;
        cur_sub  = '0;
        capacity = sss_pkg::CAP_RESET;
        errors   = 0;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    // Zero behaves as one, and anything above the row size saturates.
    function logic [4:0] usable_capacity();
        if (capacity == 0) return 5'd1;
        if (capacity > 5'd16) return 5'd16;
        return capacity;
    endfunction

    function logic [31:0] take_top(logic [3:0] s);
        logic [4:0] n;
        n = fill[s] - 5'd1;
        fill[s] = n;
        if (s == cur_sub && n == 0 && cur_sub != 0) cur_sub = cur_sub - 4'd1;
        return plates[s][n[3:0]];
    endfunction

    function void note_request(logic [sss_pkg::OP_W-1:0] op, logic [31:0] val,
                               logic [sss_pkg::IDX_W-1:0] idx);
        t_stack_result r;
        logic [3:0]    s;
        logic [4:0]    lim;
        lim      = usable_capacity();
        r.value  = '0;
        r.status = sss_pkg::ST_OK;
        case (op)
            sss_pkg::OP_PUSH: begin
                s = cur_sub;
                if (fill[s] >= lim) begin
                    if (s != 4'd15 && fill[s + 4'd1] < lim) s = s + 4'd1;
                    else r.status = sss_pkg::ST_FULL;
                end
                if (r.status == sss_pkg::ST_OK) begin
                    cur_sub = s;
                    plates[s][fill[s][3:0]] = val;
                    fill[s] = fill[s] + 5'd1;
                end
            end
            sss_pkg::OP_POP: begin
                if (fill[cur_sub] == 0) r.status = sss_pkg::ST_EMPTY;
                else r.value = take_top(cur_sub);
            end
            sss_pkg::OP_POP_AT: begin
                // The range check wins over the empty check.
                if (idx > cur_sub) r.status = sss_pkg::ST_BEYOND;
                else if (fill[idx] == 0) r.status = sss_pkg::ST_EMPTY;
                else r.value = take_top(idx);
            end
            default: ;
        endcase
        r.cur = cur_sub;
        pending_results.insert(pending_results.size(), r);
    endfunction

    task report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    task check_response(logic [31:0] v, logic [sss_pkg::STAT_W-1:0] st,
                        logic [sss_pkg::IDX_W-1:0] c);
        t_stack_result w;
        if (pending_results.size() == 0) begin
            report($sformatf("unexpected item value=%h status=%0d index=%0d", v, st, c));
            return;
        end
        w = pending_results.pop_front();
        if (v !== w.value) report($sformatf("popped value %h, want %h", v, w.value));
        if (st !== w.status) report($sformatf("status %0d, want %0d", st, w.status));
        if (c !== w.cur) report($sformatf("current index %0d, want %0d", c, w.cur));
    endtask
endclass

module tb_segmented_stack_set;
    import sss_pkg::*;

    localparam int DATA_W         = 32;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 80;

    typedef enum int {FILL_RUN, DRAIN_RUN, MIXED_RUN} t_run_kind;

    logic              i_clk             = 1'b0;
    logic              i_rst_n           = 1'b0;
    logic              i_cfg_we          = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata       = '0;
    logic              i_valid           = 1'b0;
    logic [OP_W-1:0]   i_op              = OP_NOP;
    logic [DATA_W-1:0] i_push_value      = '0;
    logic [IDX_W-1:0]  i_sub_stack_index = '0;
    logic              i_stall           = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [DATA_W-1:0] o_popped_value;
    logic [STAT_W-1:0] o_status;
    logic [IDX_W-1:0]  o_current_index;

    bit src_idle_en = 1'b0;
    bit snk_idle_en = 1'b0;
    bit hold_req    = 1'b0;
    int idle_cycles = 0;

    stack_set_scoreboard sb = new();

    segmented_stack_set u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_op              (i_op),
        .i_push_value      (i_push_value),
        .i_sub_stack_index (i_sub_stack_index),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_popped_value    (o_popped_value),
        .o_status          (o_status),
        .o_current_index   (o_current_index)
    );

    always #6 i_clk = ~i_clk;

    // Both handshakes are sampled here, so the model sees items in acceptance order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_request(i_op, i_push_value, i_sub_stack_index);
            if (o_valid && !i_stall) sb.check_response(o_popped_value, o_status,
                                                       o_current_index);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Entered at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(logic [OP_W-1:0] op, logic [DATA_W-1:0] val,
                             logic [IDX_W-1:0] idx);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_op              <= op;
        i_push_value      <= val;
        i_sub_stack_index <= idx;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic drain_and_settle();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] cap);
        drain_and_settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.capacity = cap;
    endtask

    task automatic pick_and_send(t_run_kind kind, output bit counted);
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] val;
        logic [IDX_W-1:0]  idx;
        int                r;
        r = $urandom_range(0, 99);
        case (kind)
            FILL_RUN:  op = (r < 85) ? OP_PUSH : ((r < 93) ? OP_POP : OP_POP_AT);
            DRAIN_RUN: op = (r < 10) ? OP_PUSH : ((r < 55) ? OP_POP : OP_POP_AT);
            default:   op = (r < 45) ? OP_PUSH : ((r < 70) ? OP_POP :
                            ((r < 95) ? OP_POP_AT : OP_NOP));
        endcase
        case ($urandom_range(0, 9))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            2:       val = '0;
            3:       val = '1;
            default: val = $urandom;
        endcase
        // Mostly name a sub-stack at or below the current one so pops land.
        if ($urandom_range(0, 3) != 0) idx = $urandom_range(0, sb.cur_sub);
        else idx = $urandom_range(0, 15);
        send_item(op, val, idx);
        counted = (op != OP_NOP);
    endtask

    task automatic random_items(int count);
        int        done;
        int        run_left;
        t_run_kind kind;
        bit        counted;
        done     = 0;
        run_left = 0;
        kind     = MIXED_RUN;
        while (done < count) begin
            if (run_left == 0) begin
                kind     = t_run_kind'($urandom_range(0, 2));
                run_left = (kind == FILL_RUN) ? $urandom_range(10, 60) : $urandom_range(1, 40);
            end
            pick_and_send(kind, counted);
            run_left--;
            if (counted) done++;
        end
    endtask

    initial begin
        logic [CFG_W-1:0] caps [10];
        caps = '{5'd31, 5'd1, 5'd5, 5'd2, 5'd9, 5'd3, 5'd16, 5'd0, 5'd12, 5'd4};

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Corner items at the reset capacity.
        send_item(OP_POP, '0, '0);
        send_item(OP_POP_AT, $urandom, 4'd5);
        send_item(OP_NOP, '1, 4'hF);
        send_item(OP_PUSH, 32'h8000_0000, 4'hF);
        send_item(OP_PUSH, 32'h7FFF_FFFF, '0);
        send_item(OP_POP_AT, '0, '0);
        send_item(OP_PUSH, '0, '0);
        send_item(OP_POP_AT, '0, 4'hF);

        // Capacity zero acts as one, leaving sub-stack 0 over its limit; fill everything.
        write_capacity(5'd0);
        for (int k = 0; k < 15; k++) send_item(OP_PUSH, $urandom, k[3:0]);
        send_item(OP_PUSH, '1, '0);
        send_item(OP_POP_AT, '0, '0);
        send_item(OP_POP_AT, '0, '0);
        send_item(OP_POP_AT, '0, '0);
        send_item(OP_POP, '0, '0);

        for (int p = 0; p < 10; p++) begin
            write_capacity(caps[p]);
            src_idle_en = ($urandom_range(0, 3) != 0);
            snk_idle_en = ($urandom_range(0, 3) != 0);
            // Stall the result side long enough that the input backs up.
            if (p == 2) hold_req = 1'b1;
            random_items(140);
        end

        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        write_capacity(5'd16);
        random_items(300);

        drain_and_settle();
        repeat (10) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
